// File: hw/rtl/mrc_pkg.sv
// Shared types and constants of the Modbus RTU response checker.
// No dependencies; mrc_frame, mrc_judge and the top level refer to it by scoped names.
package mrc_pkg;

	localparam int RELAY_W = 8;
	localparam int VALUE_W = 16;

	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam int          FN_EXCEPTION_BIT   = 7;
	localparam logic [7:0]  FN_WRITE_ONE       = 8'h06;
	localparam logic [7:0]  FN_READ_HOLD       = 8'h03;
	localparam logic [7:0]  FN_READ_INPUT      = 8'h04;
	localparam logic [7:0]  PM_BYTE_COUNT      = 8'h0C;
	localparam logic [7:0]  GAS_BYTE_COUNT     = 8'h02;
	localparam logic [7:0]  CLIMATE_BYTE_COUNT = 8'h04;
	localparam logic [15:0] RELAY_ON_WORD      = 16'h0001;

	localparam logic [7:0] HEADER_LEN      = 8'd3;
	localparam logic [7:0] DATA_LAST_POS   = 8'd18;
	localparam logic [7:0] POS_MAX         = 8'd255;
	localparam logic [7:0] MIN_FRAME_LEN   = 8'd4;
	localparam logic [7:0] WRITE_MIN_LEN   = 8'd8;
	localparam logic [7:0] CLIMATE_MIN_LEN = 8'd7;
	localparam logic [7:0] PM_MIN_LEN      = 8'd9;
	localparam logic [7:0] GAS_MIN_LEN     = 8'd7;

	localparam logic [4:0] MODE_READ_RELAYS = 5'd16;
	localparam logic [4:0] MODE_CLIMATE     = 5'd17;
	localparam logic [4:0] MODE_PARTICLES   = 5'd18;
	localparam logic [4:0] MODE_GAS         = 5'd19;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_RESP = 2'd1,
		ST_CRC  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_RELAY_ADDR    = 2'd0,
		CFG_CLIMATE_ADDR  = 2'd1,
		CFG_PARTICLE_ADDR = 2'd2,
		CFG_FUME_ADDR     = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic                 crc_zero;
		logic [7:0]           len;
		logic [7:0]           addr;
		logic [7:0]           fn;
		logic [7:0]           cnt;
		logic [VALUE_W-1:0]   val0;
		logic [VALUE_W-1:0]   val1;
		logic [RELAY_W-1:0]   relays;
	} frame_view_t;

	typedef struct packed {
		status_t    status;
		logic       relay_write;
		logic       relay_load;
		logic [2:0] channel;
		logic       level;
		logic       climate_load;
		logic       particle_load;
		logic       fume_load;
	} verdict_t;

endpackage

// File: hw/rtl/mrc_frame.sv
// Per-frame accumulator: running CRC16, byte count, header and data capture.
// Depends on mrc_pkg.
module mrc_frame #(
	parameter int CHANNELS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          rx_byte,
	input  logic                frame_end,
	output mrc_pkg::frame_view_t view
);

	logic [15:0]                 crc_q;
	logic [7:0]                  pos_q;
	logic [7:0]                  hdr_q [3];
	logic [15:0]                 word_q;
	logic [15:0]                 val_q [2];
	logic [mrc_pkg::RELAY_W-1:0] rel_q;

	logic [15:0]                 crc_n;
	logic [7:0]                  pos_n;
	logic [7:0]                  hdr_n [3];
	logic [15:0]                 word_n;
	logic [15:0]                 val_n [2];
	logic [mrc_pkg::RELAY_W-1:0] rel_n;
	logic [15:0]                 w;
	logic [2:0]                  idx;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) c = (c >> 1) ^ mrc_pkg::CRC_POLY;
			else      c = c >> 1;
		end
		return c;
	endfunction

	always_comb begin
		crc_n  = crc_step(crc_q, rx_byte);
		pos_n  = (pos_q == mrc_pkg::POS_MAX) ? pos_q : pos_q + 8'd1;
		hdr_n  = hdr_q;
		word_n = word_q;
		val_n  = val_q;
		rel_n  = rel_q;
		w      = word_q | {8'h00, rx_byte};
		idx    = 3'((pos_q - 8'd4) >> 1);
		if (pos_q < mrc_pkg::HEADER_LEN) begin
			hdr_n[pos_q[1:0]] = rx_byte;
		end else if (pos_q <= mrc_pkg::DATA_LAST_POS) begin
			if (pos_q[0]) begin
				word_n = {rx_byte, 8'h00};
			end else begin
				if (idx < 3'd2) val_n[idx[0]] = w;
				if ({5'd0, idx} < 8'(CHANNELS) && w == mrc_pkg::RELAY_ON_WORD)
					rel_n[idx] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= mrc_pkg::CRC_SEED;
			pos_q  <= '0;
			hdr_q  <= '{default: '0};
			word_q <= '0;
			val_q  <= '{default: '0};
			rel_q  <= '0;
		end else if (advance) begin
			if (frame_end) begin
				crc_q  <= mrc_pkg::CRC_SEED;
				pos_q  <= '0;
				hdr_q  <= '{default: '0};
				word_q <= '0;
				val_q  <= '{default: '0};
				rel_q  <= '0;
			end else begin
				crc_q  <= crc_n;
				pos_q  <= pos_n;
				hdr_q  <= hdr_n;
				word_q <= word_n;
				val_q  <= val_n;
				rel_q  <= rel_n;
			end
		end
	end

	assign view.crc_zero = (crc_n == 16'h0000);
	assign view.len      = pos_n;
	assign view.addr     = hdr_n[0];
	assign view.fn       = hdr_n[1];
	assign view.cnt      = hdr_n[2];
	assign view.val0     = val_n[0];
	assign view.val1     = val_n[1];
	assign view.relays   = rel_n;

endmodule

// File: hw/rtl/mrc_judge.sv
// Frame-end checks against the outstanding request; yields status and store updates.
// Depends on mrc_pkg.
module mrc_judge #(
	parameter int CHANNELS = 8
) (
	input  mrc_pkg::frame_view_t view,
	input  logic [4:0]           mode,
	input  logic [7:0]           relay_unit_address,
	input  logic [7:0]           climate_unit_address,
	input  logic [7:0]           particle_unit_address,
	input  logic [7:0]           fume_unit_address,
	output mrc_pkg::verdict_t    verdict
);

	localparam logic [7:0] RELAY_COUNT   = 8'(2 * CHANNELS);
	localparam logic [7:0] RELAY_MIN_LEN = 8'(5 + 2 * CHANNELS);

	logic [2:0] ch;
	logic       level;

	assign ch    = mode[3:1];
	assign level = ~mode[0];

	always_comb begin
		verdict               = '0;
		verdict.status        = mrc_pkg::ST_RESP;
		verdict.channel       = ch;
		verdict.level         = level;
		if (view.len < mrc_pkg::MIN_FRAME_LEN) begin
			verdict.status = mrc_pkg::ST_RESP;
		end else if (!view.crc_zero) begin
			verdict.status = mrc_pkg::ST_CRC;
		end else if (view.fn[mrc_pkg::FN_EXCEPTION_BIT]) begin
			verdict.status = mrc_pkg::ST_RESP;
		end else if (mode < mrc_pkg::MODE_READ_RELAYS) begin
			if (view.addr == relay_unit_address && view.fn == mrc_pkg::FN_WRITE_ONE &&
			    view.len >= mrc_pkg::WRITE_MIN_LEN && view.cnt == 8'h00 &&
			    view.val0 == {5'd0, ch, 8'h00} && view.val1[15:8] == {7'd0, level}) begin
				verdict.status      = mrc_pkg::ST_OK;
				verdict.relay_write = ({5'd0, ch} < 8'(CHANNELS));
			end
		end else begin
			unique case (mode)
				mrc_pkg::MODE_READ_RELAYS: begin
					if (view.addr == relay_unit_address && view.fn == mrc_pkg::FN_READ_HOLD &&
					    view.cnt == RELAY_COUNT) begin
						verdict.status     = mrc_pkg::ST_OK;
						verdict.relay_load = (view.len >= RELAY_MIN_LEN);
					end
				end
				mrc_pkg::MODE_CLIMATE: begin
					if (view.addr == climate_unit_address && view.fn == mrc_pkg::FN_READ_HOLD) begin
						verdict.status       = mrc_pkg::ST_OK;
						verdict.climate_load = (view.len >= mrc_pkg::CLIMATE_MIN_LEN) &&
						                       (view.cnt == mrc_pkg::CLIMATE_BYTE_COUNT);
					end
				end
				mrc_pkg::MODE_PARTICLES: begin
					if (view.addr == particle_unit_address && view.fn == mrc_pkg::FN_READ_HOLD &&
					    view.cnt == mrc_pkg::PM_BYTE_COUNT) begin
						verdict.status        = mrc_pkg::ST_OK;
						verdict.particle_load = (view.len >= mrc_pkg::PM_MIN_LEN);
					end
				end
				mrc_pkg::MODE_GAS: begin
					if (view.addr == fume_unit_address && view.fn == mrc_pkg::FN_READ_INPUT &&
					    view.cnt == mrc_pkg::GAS_BYTE_COUNT) begin
						verdict.status    = mrc_pkg::ST_OK;
						verdict.fume_load = (view.len >= mrc_pkg::GAS_MIN_LEN);
					end
				end
				default: verdict.status = mrc_pkg::ST_RESP;
			endcase
		end
	end

endmodule

// File: hw/rtl/modbus_response_checker.sv
// Modbus RTU master response checker, top level.
// Depends on mrc_pkg, mrc_frame and mrc_judge.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one response byte per transaction
//   with frame_end marking the last byte and mode giving the outstanding request.
//   Each transaction first lands in an input register; from there it enters the
//   CRC and capture logic, and a frame-end byte is judged in that same cycle.
//   Output channel (out_valid/out_ready) carries one result per frame: status and
//   the stored relay bits and sensor values after any update made by that frame.
//   Path: a frame-end byte passes the input register and the judge; the result is registered.
//   Throughput: one byte per cycle while no frame-end byte is held, set by the CRC update.
//   Stall: while a result waits, bytes inside a frame still flow; a frame-end byte
//   holds in the input register and in_ready drops until the result is taken.
//   Configuration: cfg_we writes one slave address register per cycle, index from
//   cfg_index; write only while no transaction is in flight.
//   Reset: arst_n clears the frame state, the CRC to 0xFFFF, the relay and sensor
//   stores to zero and the addresses to 2, 1, 3 and 4.
module modbus_response_checker #(
	parameter int CHANNELS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	input  logic               frame_end,
	input  logic [4:0]         mode,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [7:0]         relay_bits,
	output logic [15:0]        humidity_tenths,
	output logic signed [15:0] temperature_tenths,
	output logic [15:0]        fine_dust,
	output logic [15:0]        coarse_dust,
	output logic [15:0]        fume_level
);

	localparam logic [7:0] CH_MASK = 8'((16'd1 << CHANNELS) - 16'd1);

	logic [7:0] relay_addr_q;
	logic [7:0] climate_addr_q;
	logic [7:0] particle_addr_q;
	logic [7:0] fume_addr_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic [4:0] mode_s1;

	logic             out_valid_q;
	mrc_pkg::status_t status_q;

	logic [7:0]         relay_q;
	logic [15:0]        humidity_q;
	logic signed [15:0] temperature_q;
	logic [15:0]        fine_q;
	logic [15:0]        coarse_q;
	logic [15:0]        fume_q;

	logic                 out_free;
	logic                 s1_fire;
	logic                 result_fire;
	mrc_pkg::frame_view_t view;
	mrc_pkg::verdict_t    verdict;

	assign out_free    = !out_valid_q || out_ready;
	assign s1_fire     = valid_s1 && (!end_s1 || out_free);
	assign result_fire = s1_fire && end_s1;
	assign in_ready    = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_addr_q    <= 8'd2;
			climate_addr_q  <= 8'd1;
			particle_addr_q <= 8'd3;
			fume_addr_q     <= 8'd4;
		end else if (cfg_we) begin
			unique case (mrc_pkg::cfg_index_t'(cfg_index))
				mrc_pkg::CFG_RELAY_ADDR:    relay_addr_q    <= cfg_data;
				mrc_pkg::CFG_CLIMATE_ADDR:  climate_addr_q  <= cfg_data;
				mrc_pkg::CFG_PARTICLE_ADDR: particle_addr_q <= cfg_data;
				mrc_pkg::CFG_FUME_ADDR:     fume_addr_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
			end_s1  <= frame_end;
			mode_s1 <= mode;
		end
	end

	mrc_frame #(
		.CHANNELS(CHANNELS)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (s1_fire),
		.rx_byte  (byte_s1),
		.frame_end(end_s1),
		.view     (view)
	);

	mrc_judge #(
		.CHANNELS(CHANNELS)
	) u_judge (
		.view                 (view),
		.mode                 (mode_s1),
		.relay_unit_address   (relay_addr_q),
		.climate_unit_address (climate_addr_q),
		.particle_unit_address(particle_addr_q),
		.fume_unit_address    (fume_addr_q),
		.verdict              (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			status_q      <= mrc_pkg::ST_OK;
			relay_q       <= '0;
			humidity_q    <= '0;
			temperature_q <= '0;
			fine_q        <= '0;
			coarse_q      <= '0;
			fume_q        <= '0;
		end else begin
			if (result_fire) begin
				out_valid_q <= 1'b1;
				status_q    <= verdict.status;
				if (verdict.relay_write)
					relay_q[verdict.channel] <= verdict.level;
				if (verdict.relay_load)
					relay_q <= (relay_q & ~CH_MASK) | (view.relays & CH_MASK);
				if (verdict.climate_load) begin
					humidity_q    <= view.val0;
					temperature_q <= view.val1;
				end
				if (verdict.particle_load) begin
					fine_q   <= view.val0;
					coarse_q <= view.val1;
				end
				if (verdict.fume_load)
					fume_q <= view.val0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign relay_bits         = relay_q;
	assign humidity_tenths    = humidity_q;
	assign temperature_tenths = temperature_q;
	assign fine_dust          = fine_q;
	assign coarse_dust        = coarse_q;
	assign fume_level         = fume_q;

endmodule

// File: hw/rtl/mrc_checker.sv
// Port-level checks of the response checker, attached by bind.
// Depends on modbus_response_checker's port list only.
module mrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [7:0]  relay_bits,
	input logic [15:0] humidity_tenths,
	input logic [15:0] temperature_tenths,
	input logic [15:0] fine_dust,
	input logic [15:0] coarse_dust,
	input logic [15:0] fume_level
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(relay_bits))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_stores_move_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!$rose(out_valid) && !$past(out_valid && out_ready) |->
		$stable(relay_bits) && $stable(humidity_tenths) && $stable(temperature_tenths) &&
		$stable(fine_dust) && $stable(coarse_dust) && $stable(fume_level))
		else $error("stored values changed without a new transaction");

	a_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid && relay_bits == 8'd0 && fume_level == 16'd0)
		else $error("stores not cleared by reset");

endmodule

bind modbus_response_checker mrc_checker u_mrc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.status            (status),
	.relay_bits        (relay_bits),
	.humidity_tenths   (humidity_tenths),
	.temperature_tenths(temperature_tenths),
	.fine_dust         (fine_dust),
	.coarse_dust       (coarse_dust),
	.fume_level        (fume_level)
);
